>>> hdl/ttg_pkg.sv
package ttg_pkg;

    // Default grid size
    localparam int ROWS_DEF    = 22;
    localparam int COLS_DEF    = 68;
    localparam int QUEUE_DEPTH = 2;

    // Action codes on the input word
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;
    localparam logic [6:0] BLANK    = 7'h20;

    // Classified command passed from front to back
    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_LF    = 3'd1,
        OP_CR    = 3'd2,
        OP_BS    = 3'd3,
        OP_PRINT = 3'd4,
        OP_READ  = 3'd5,
        OP_CLEAR = 3'd6
    } op_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_t;

    typedef struct packed {
        logic [6:0] cell_char;
        logic [4:0] cursor_line;
        logic [6:0] cursor_column;
        logic       scrolled;
    } out_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] chr;
        logic [4:0] row;
        logic [6:0] col;
    } cmd_t;

endpackage

>>> hdl/text_terminal_grid.sv
// Character-cell text console of ROWS x COLS cells with a cursor.
// Input channel: drive a word on item and raise push; the word is taken on
// a clock edge with push high and full low. An action puts one character
// (line feed, carriage return, backspace, printable byte), reads one cell,
// or clears the grid and homes the cursor.
// Result channel: while empty is low the oldest result word sits on result;
// raise pop to take it. Every input word gives exactly one result word,
// carrying the cell read (zero unless a read), the cursor after the word,
// and whether the grid scrolled.
// Path: a taken word waits in the command queue, then is executed and its
// result registered; a read of a written row also passes the read wait.
// A put into a row not written since reset, clear or scroll sweeps that
// row, one cell a cycle, blanking it and placing the character. Clear and
// scroll need no pass: rows carry a written flag, and the row offset ring
// turns on scroll. Flow: a new command starts only after the previous
// result is taken. A two-word command queue parts the decoder from the
// executing part; if the receiver stalls, the result is held, the queue
// fills, then full rises.
// Reset: grid reads all spaces, cursor at the top left, queues empty; no
// clearing pass, items are taken from the first cycle after reset.
module text_terminal_grid
    import ttg_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  in_t  item,
    output logic full,
    input  logic pop,
    output out_t result,
    output logic empty
);

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic cmd_empty;
    logic cmd_pop;

    // Classify the incoming word
    ttg_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .item (item),
        .cmd  (front_cmd)
    );

    // Hold decoded commands until the back part is free
    ttg_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_cmd),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    // Execute commands against the cursor and the cell store
    ttg_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

>>> hdl/ttg_front.sv
module ttg_front
    import ttg_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)(
    input  in_t  item,
    output cmd_t cmd
);

    logic row_in_range;
    logic col_in_range;

    assign row_in_range = 32'(item.read_row) < ROWS;
    assign col_in_range = 32'(item.read_col) < COLS;

    always_comb
    begin
        cmd.op  = OP_NOP;
        cmd.chr = item.char_code[6:0];
        cmd.row = item.read_row;
        cmd.col = item.read_col;
        case (item.action)
            ACT_PUT:
            begin
                if (item.char_code == CH_LF)
                begin
                    cmd.op = OP_LF;
                end
                else if (item.char_code == CH_CR)
                begin
                    cmd.op = OP_CR;
                end
                else if (item.char_code == CH_BS)
                begin
                    cmd.op = OP_BS;
                end
                else if (item.char_code inside {[PRINT_LO:PRINT_HI]})
                begin
                    cmd.op = OP_PRINT;
                end
            end
            ACT_READ:
            begin
                // out-of-range reads report zero and touch nothing
                if (row_in_range && col_in_range)
                begin
                    cmd.op = OP_READ;
                end
            end
            ACT_CLEAR:
            begin
                cmd.op = OP_CLEAR;
            end
            default:
            begin
                cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

>>> hdl/ttg_fifo.sv
module ttg_fifo
    import ttg_pkg::*;
#(
    parameter int WIDTH = $bits(cmd_t),
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_COUNT = NW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/ttg_back.sv
module ttg_back
    import ttg_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_empty,
    input  cmd_t cmd,
    output logic cmd_pop,
    output out_t result,
    output logic empty,
    input  logic pop
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS + 1);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
    localparam logic [CW-1:0] WRAP_COL = CW'(COLS);
    localparam logic [RW:0]   ROWS_X   = (RW + 1)'(ROWS);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_RDWAIT = 3'b100
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        cell_addr = AW'(r) * AW'(COLS) + AW'(c);
    endfunction

    state_t          state_reg, state_next;
    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [CW-1:0]   cur_col_reg, cur_col_next;
    logic [RW-1:0]   cur_phys_reg, cur_phys_next;
    logic [RW-1:0]   top_reg, top_next;
    logic [ROWS-1:0] row_ok_reg, row_ok_next;
    logic [CW-1:0]   sweep_reg, sweep_next;
    logic            res_valid_reg, res_valid_next;
    out_t            res_reg, res_next;
    out_t            pend_res_reg, pend_res_next;
    logic [RW-1:0]   pend_phys_reg, pend_phys_next;
    logic [CW-1:0]   pend_col_reg, pend_col_next;
    logic [6:0]      pend_chr_reg, pend_chr_next;

    logic [6:0]      mem [DEPTH];
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [6:0]      mem_wdata, mem_rdata_reg;

    logic            adv_scroll;
    logic [RW-1:0]   adv_row, adv_phys, adv_top;
    logic [RW:0]     rd_sum;
    logic [RW-1:0]   rd_phys;
    logic [RW-1:0]   tgt_phys;
    logic [CW-1:0]   tgt_col;
    logic            tgt_ok;
    logic            defer, scr;
    logic [6:0]      rd_char;
    out_t            item_res;

    assign result = res_reg;
    assign empty  = !res_valid_reg;

    // Line advance: the cursor row moves down, or the ring turns by one row
    always_comb
    begin
        adv_scroll = (cur_row_reg == LAST_ROW);
        adv_row    = adv_scroll ? cur_row_reg : cur_row_reg + 1'b1;
        adv_phys   = adv_scroll ? top_reg
                   : ((cur_phys_reg == LAST_ROW) ? '0 : cur_phys_reg + 1'b1);
        adv_top    = !adv_scroll ? top_reg
                   : ((top_reg == LAST_ROW) ? '0 : top_reg + 1'b1);
        rd_sum     = {1'b0, RW'(cmd.row)} + {1'b0, top_reg};
        rd_phys    = (rd_sum >= ROWS_X) ? RW'(rd_sum - ROWS_X) : RW'(rd_sum);
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_phys_next  = cur_phys_reg;
        top_next       = top_reg;
        row_ok_next    = row_ok_reg;
        sweep_next     = sweep_reg;
        res_valid_next = res_valid_reg && !pop;
        res_next       = res_reg;
        pend_res_next  = pend_res_reg;
        pend_phys_next = pend_phys_reg;
        pend_col_next  = pend_col_reg;
        pend_chr_next  = pend_chr_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = BLANK;
        cmd_pop        = 1'b0;
        tgt_phys       = cur_phys_reg;
        tgt_col        = cur_col_reg;
        tgt_ok         = 1'b0;
        defer          = 1'b0;
        scr            = 1'b0;
        rd_char        = '0;
        item_res       = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && !res_valid_reg)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_LF:
                        begin
                            cur_row_next  = adv_row;
                            cur_phys_next = adv_phys;
                            top_next      = adv_top;
                            cur_col_next  = '0;
                            scr           = adv_scroll;
                            if (adv_scroll)
                            begin
                                row_ok_next[top_reg] = 1'b0;
                            end
                        end
                        OP_CR:
                        begin
                            cur_col_next = '0;
                        end
                        OP_BS:
                        begin
                            if (cur_col_reg != '0)
                            begin
                                cur_col_next = cur_col_reg - 1'b1;
                                // a row never written already reads blank
                                if (row_ok_reg[cur_phys_reg])
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = cell_addr(cur_phys_reg, cur_col_next);
                                    mem_wdata = BLANK;
                                end
                            end
                        end
                        OP_PRINT:
                        begin
                            if (cur_col_reg == WRAP_COL)
                            begin
                                cur_row_next  = adv_row;
                                cur_phys_next = adv_phys;
                                top_next      = adv_top;
                                scr           = adv_scroll;
                                tgt_phys      = adv_phys;
                                tgt_col       = '0;
                                tgt_ok        = !adv_scroll && row_ok_reg[adv_phys];
                                if (adv_scroll)
                                begin
                                    row_ok_next[top_reg] = 1'b0;
                                end
                            end
                            else
                            begin
                                tgt_ok = row_ok_reg[cur_phys_reg];
                            end
                            cur_col_next = tgt_col + 1'b1;
                            if (tgt_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr(tgt_phys, tgt_col);
                                mem_wdata = cmd.chr;
                            end
                            else
                            begin
                                // fresh row: blank it while placing the character
                                row_ok_next[tgt_phys] = 1'b1;
                                pend_phys_next        = tgt_phys;
                                pend_col_next         = tgt_col;
                                pend_chr_next         = cmd.chr;
                                sweep_next            = '0;
                                state_next            = ST_SWEEP;
                                defer                 = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (row_ok_reg[rd_phys])
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = cell_addr(rd_phys, CW'(cmd.col));
                                state_next = ST_RDWAIT;
                                defer      = 1'b1;
                            end
                            else
                            begin
                                rd_char = BLANK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            row_ok_next   = '0;
                            cur_row_next  = '0;
                            cur_col_next  = '0;
                            cur_phys_next = top_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                    item_res.cell_char     = rd_char;
                    item_res.cursor_line   = 5'(cur_row_next);
                    item_res.cursor_column = 7'(cur_col_next);
                    item_res.scrolled      = scr;
                    if (defer)
                    begin
                        pend_res_next = item_res;
                    end
                    else
                    begin
                        res_next       = item_res;
                        res_valid_next = 1'b1;
                    end
                end
            end
            ST_SWEEP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cell_addr(pend_phys_reg, sweep_reg);
                mem_wdata  = (sweep_reg == pend_col_reg) ? pend_chr_reg : BLANK;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_COL)
                begin
                    res_next       = pend_res_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RDWAIT:
            begin
                res_next           = pend_res_reg;
                res_next.cell_char = mem_rdata_reg;
                res_valid_next     = 1'b1;
                state_next         = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cur_phys_reg  <= '0;
            top_reg       <= '0;
            row_ok_reg    <= '0;
            sweep_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            cur_phys_reg  <= cur_phys_next;
            top_reg       <= top_next;
            row_ok_reg    <= row_ok_next;
            sweep_reg     <= sweep_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        pend_res_reg  <= pend_res_next;
        pend_phys_reg <= pend_phys_next;
        pend_col_reg  <= pend_col_next;
        pend_chr_reg  <= pend_chr_next;
    end

    // Cell store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

>>> tb/text_terminal_grid_tb.sv
module text_terminal_grid_tb;
    import ttg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = ROWS_DEF;
    localparam int COLS = COLS_DEF;

    // The package names actions 0..2 only; action 3 is a no-op on the input word
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 1350;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int HOLD_AFTER   = 300;   // results taken before the hold-off starts
    localparam int PAUSE_AT     = 700;   // plan index where the sender drains the block

    // One planned input word. Where typed is set, want is the result read straight
    // off the console rules; otherwise the console model below supplies it.
    typedef struct {
        in_t  w;
        bit   typed;
        out_t want;
    } plan_t;

    logic clk;
    logic rst_n;
    logic push;
    in_t  item;
    logic full;
    logic pop;
    out_t result;
    logic empty;

    text_terminal_grid #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .item(item),
        .full(full),
        .pop(pop),
        .result(result),
        .empty(empty)
    );

    // ------------------------------------------------------------------
    // Console model: its own copy of the grid and the cursor
    // ------------------------------------------------------------------
    logic [6:0] screen [ROWS][COLS];
    logic [4:0] cur_line;
    logic [6:0] cur_col;

    // Fill every cell with a space and home the cursor
    function automatic void wipe_screen();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                screen[r][c] = BLANK;
        cur_line = '0;
        cur_col  = '0;
    endfunction

    // Go to column 0 of the next row; on the last row scroll up and blank
    // the new bottom row instead. Return 1 when the grid scrolled.
    function automatic bit line_feed();
        cur_col = '0;
        if (int'(cur_line) + 1 < ROWS)
        begin
            cur_line = cur_line + 5'd1;
            return 1'b0;
        end
        for (int r = 0; r < ROWS - 1; r++)
            for (int c = 0; c < COLS; c++)
                screen[r][c] = screen[r + 1][c];
        for (int c = 0; c < COLS; c++)
            screen[ROWS - 1][c] = BLANK;
        return 1'b1;
    endfunction

    // Apply one input word to the model and return the result word it gives
    function automatic out_t console_step(in_t w);
        out_t r;
        r = '0;
        case (w.action)
            ACT_PUT:
            begin
                if (w.char_code == CH_LF)
                begin
                    r.scrolled = line_feed();
                end
                else if (w.char_code == CH_CR)
                begin
                    cur_col = '0;
                end
                else if (w.char_code == CH_BS)
                begin
                    // At column 0 backspace does nothing; with a wrap pending it
                    // lands on the last column and blanks it
                    if (cur_col != 0)
                    begin
                        cur_col = cur_col - 7'd1;
                        screen[cur_line][cur_col] = BLANK;
                    end
                end
                else if (w.char_code >= PRINT_LO && w.char_code <= PRINT_HI)
                begin
                    // Deferred wrap: the newline happens only when the next
                    // printable byte arrives
                    if (int'(cur_col) >= COLS)
                        r.scrolled = line_feed();
                    screen[cur_line][cur_col] = w.char_code[6:0];
                    cur_col = cur_col + 7'd1;
                end
            end
            ACT_READ:
            begin
                if (int'(w.read_row) < ROWS && int'(w.read_col) < COLS)
                    r.cell_char = screen[w.read_row][w.read_col];
            end
            ACT_CLEAR:
            begin
                wipe_screen();
            end
            default:
            begin
            end
        endcase
        r.cursor_line   = cur_line;
        r.cursor_column = cur_col;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Opening words: extremes, every action and the corner cases
    // ------------------------------------------------------------------
    localparam out_t HOME_ZERO  = '{7'h00, 5'd0, 7'd0, 1'b0};
    localparam out_t HOME_BLANK = '{BLANK, 5'd0, 7'd0, 1'b0};

    plan_t opening_rows [23] = '{
        // freshly reset grid reads spaces at both corners
        '{'{ACT_READ,   8'd0,     5'd0,  7'd0},   1'b1, HOME_BLANK},
        '{'{ACT_READ,   8'd0,     5'd21, 7'd67},  1'b1, HOME_BLANK},
        // reads off the grid give zero
        '{'{ACT_READ,   8'd0,     5'd22, 7'd0},   1'b1, HOME_ZERO},
        '{'{ACT_READ,   8'd0,     5'd0,  7'd68},  1'b1, HOME_ZERO},
        '{'{ACT_READ,   8'hFF,    5'd31, 7'd127}, 1'b1, HOME_ZERO},
        // unused action, then bytes that are ignored
        '{'{ACT_UNUSED, 8'hFF,    5'd31, 7'd127}, 1'b1, HOME_ZERO},
        '{'{ACT_PUT,    CH_BS,    5'd0,  7'd0},   1'b1, HOME_ZERO},
        '{'{ACT_PUT,    8'd0,     5'd31, 7'd127}, 1'b1, HOME_ZERO},
        '{'{ACT_PUT,    8'd31,    5'd0,  7'd0},   1'b1, HOME_ZERO},
        '{'{ACT_PUT,    8'd127,   5'd0,  7'd0},   1'b1, HOME_ZERO},
        '{'{ACT_PUT,    8'd255,   5'd0,  7'd0},   1'b1, HOME_ZERO},
        // lowest and highest printable bytes and one more, then a backspace over that one
        '{'{ACT_PUT,    PRINT_LO, 5'd0,  7'd0},   1'b0, HOME_ZERO},
        '{'{ACT_PUT,    PRINT_HI, 5'd0,  7'd0},   1'b0, HOME_ZERO},
        '{'{ACT_PUT,    8'h51,    5'd0,  7'd0},   1'b0, HOME_ZERO},
        '{'{ACT_PUT,    CH_BS,    5'd0,  7'd0},   1'b0, HOME_ZERO},
        '{'{ACT_READ,   8'd0,     5'd0,  7'd2},   1'b0, HOME_ZERO},
        '{'{ACT_READ,   8'd0,     5'd0,  7'd1},   1'b0, HOME_ZERO},
        '{'{ACT_PUT,    CH_CR,    5'd0,  7'd0},   1'b0, HOME_ZERO},
        '{'{ACT_PUT,    CH_LF,    5'd0,  7'd0},   1'b0, HOME_ZERO},
        '{'{ACT_PUT,    8'h41,    5'd0,  7'd0},   1'b0, HOME_ZERO},
        '{'{ACT_READ,   8'd0,     5'd1,  7'd0},   1'b0, HOME_ZERO},
        // clear homes the cursor and blanks what was written
        '{'{ACT_CLEAR,  8'd0,     5'd0,  7'd0},   1'b1, HOME_ZERO},
        '{'{ACT_READ,   8'd0,     5'd1,  7'd0},   1'b1, HOME_BLANK}
    };

    plan_t plan [$];            // every word to send, in order
    out_t  results_due [$];     // expected result words, oldest first
    int    accept_idx   = 0;
    int    results_done = 0;
    int    errors       = 0;

    // Draw a word with every field random, then let the caller set what matters
    function automatic in_t any_word();
        in_t w;
        w.action    = 2'($urandom);
        w.char_code = 8'($urandom);
        w.read_row  = 5'($urandom);
        w.read_col  = 7'($urandom);
        return w;
    endfunction

    function automatic void add_word(in_t w);
        plan_t p;
        p.w     = w;
        p.typed = 1'b0;
        p.want  = '0;
        plan.push_back(p);
    endfunction

    // Random part: mostly text runs, line feeds and reads so that the cursor
    // reaches the last row and the last column often; the rest is noise.
    task automatic fill_random_plan();
        in_t w;
        int  pick;
        int  n;
        int  last;
        last = plan.size() + RANDOM_WORDS;
        while (plan.size() < last)
        begin
            pick = $urandom_range(99);
            if (pick < 28)
            begin
                // short runs mostly, some long enough to leave a wrap pending
                n = ($urandom_range(3) == 0) ? $urandom_range(60, 75)
                                             : $urandom_range(1, 12);
                repeat (n)
                begin
                    w = any_word();
                    w.action    = ACT_PUT;
                    w.char_code = 8'($urandom_range(PRINT_LO, PRINT_HI));
                    add_word(w);
                end
            end
            else if (pick < 46)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    w = any_word();
                    w.action    = ACT_PUT;
                    w.char_code = CH_LF;
                    add_word(w);
                end
            end
            else if (pick < 52)
            begin
                w = any_word();
                w.action    = ACT_PUT;
                w.char_code = CH_CR;
                add_word(w);
            end
            else if (pick < 60)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    w = any_word();
                    w.action    = ACT_PUT;
                    w.char_code = CH_BS;
                    add_word(w);
                end
            end
            else if (pick < 86)
            begin
                w = any_word();
                w.action = ACT_READ;
                // most reads land on the grid, the rest anywhere the fields allow
                if ($urandom_range(4) != 0)
                begin
                    w.read_row = 5'($urandom_range(ROWS - 1));
                    w.read_col = 7'($urandom_range(COLS - 1));
                end
                add_word(w);
            end
            else if (pick < 87)
            begin
                w = any_word();
                w.action = ACT_CLEAR;
                add_word(w);
            end
            else if (pick < 95)
            begin
                // a byte that is neither printable nor a control the console knows
                w = any_word();
                w.action = ACT_PUT;
                do
                    w.char_code = 8'($urandom);
                while ((w.char_code >= PRINT_LO && w.char_code <= PRINT_HI) ||
                       w.char_code == CH_LF || w.char_code == CH_CR ||
                       w.char_code == CH_BS);
                add_word(w);
            end
            else
            begin
                w = any_word();
                w.action = ACT_UNUSED;
                add_word(w);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("text_terminal_grid_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Scoreboard: compare each result word taken, then predict each word taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        out_t due;
        out_t got;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got = result;
                results_done++;
                if (results_due.size() == 0)
                begin
                    $error("result word with nothing expected: %h", got);
                    errors++;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (got.cell_char !== due.cell_char)
                    begin
                        $error("cell_char: expected %0d, got %0d",
                               due.cell_char, got.cell_char);
                        errors++;
                    end
                    if (got.cursor_line !== due.cursor_line)
                    begin
                        $error("cursor_line: expected %0d, got %0d",
                               due.cursor_line, got.cursor_line);
                        errors++;
                    end
                    if (got.cursor_column !== due.cursor_column)
                    begin
                        $error("cursor_column: expected %0d, got %0d",
                               due.cursor_column, got.cursor_column);
                        errors++;
                    end
                    if (got.scrolled !== due.scrolled)
                    begin
                        $error("scrolled: expected %0d, got %0d",
                               due.scrolled, got.scrolled);
                        errors++;
                    end
                end
            end
            if (push && !full)
            begin
                // always advance the model so its state tracks the block
                due = console_step(plan[accept_idx].w);
                if (plan[accept_idx].typed)
                    due = plan[accept_idx].want;
                results_due.push_back(due);
                accept_idx++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, with one long hold-off so
    // the block fills up and raises full
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int hold_left;
        bit held_once;
        mode      = 0;
        hold_left = 0;
        held_once = 1'b0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_once && results_done >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                // switch between always taking, coin-flip and mostly stalling
                if ($urandom_range(63) == 0)
                    mode = $urandom_range(2);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(1));
                    default: pop <= ($urandom_range(7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: reset, then words in bursts with random gaps
    // ------------------------------------------------------------------
    initial
    begin : sender
        int idx;
        int burst;
        int gap;
        rst_n = 1'b0;
        push  = 1'b0;
        item  = '0;
        wipe_screen();
        foreach (opening_rows[i])
            plan.push_back(opening_rows[i]);
        fill_random_plan();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idx = 0;
        while (idx < plan.size())
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && idx < plan.size())
            begin
                if (idx == PAUSE_AT)
                begin
                    // drop push and hold until every expected word has come back
                    @(negedge clk);
                    push <= 1'b0;
                    while (results_due.size() != 0)
                        @(negedge clk);
                end
                @(negedge clk);
                push <= 1'b1;
                item <= plan[idx].w;
                // hold the word until an edge with full low takes it
                do
                    @(posedge clk);
                while (full);
                idx++;
                burst--;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        push <= 1'b0;

        // drain, then give a stray word time to show up
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (COLS + 8) @(posedge clk);

        if (errors == 0)
            $display("text_terminal_grid_tb: PASS");
        else
            $display("text_terminal_grid_tb: FAIL");
        $finish;
    end

endmodule
